>>> rtl/msrt_pkg.sv
`timescale 1ns / 1ps

package msrt_pkg;

	// Table geometry.
	localparam int NUM_SLOTS = 8;
	localparam int TAG_BITS  = 16;
	localparam int SLOT_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_BITS  = $clog2(NUM_SLOTS + 1);

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_ADD_OK    = 2'd0,
		KIND_ADD_FULL  = 2'd1,
		KIND_FIRE      = 2'd2,
		KIND_IDLE_TICK = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        opcode;
		logic [31:0] now_ms;
		logic [30:0] interval;
		logic [14:0] repeat_count;
		logic        forever_req;
		logic [15:0] tag;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  slot;
		logic [15:0] fired_tag;
		logic        finished;
		logic        last;
		logic [3:0]  active_count;
	} out_item_t;

	// One timer record as kept in the slot RAM.
	typedef struct packed {
		logic [31:0]         last_time;
		logic [30:0]         period;
		logic [14:0]         remaining;
		logic                forever_flag;
		logic [TAG_BITS-1:0] tag;
	} slot_rec_t;

	localparam int REC_BITS = $bits(slot_rec_t);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                 add_go;
		logic                 tick_go;
		logic                 scan_en;
		logic                 scan_done;
		logic [SLOT_BITS-1:0] idx;
	} ctrl_cmd_t;

endpackage

>>> rtl/msrt_ram.sv
`timescale 1ns / 1ps

module msrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

>>> rtl/msrt_ctrl.sv
`timescale 1ns / 1ps

module msrt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 opcode,
	output logic                 busy,
	output msrt_pkg::ctrl_cmd_t  cmd
);

	import msrt_pkg::*;

	state_t               state_q, state_d;
	logic [SLOT_BITS-1:0] idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		cmd           = '0;
		cmd.idx       = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (opcode == OP_TICK) begin
						cmd.tick_go = 1'b1;
						idx_d       = '0;
						state_d     = ST_SCAN;
					end else begin
						cmd.add_go = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (idx_q == SLOT_BITS'(NUM_SLOTS - 1)) begin
					state_d = ST_DONE;
				end else begin
					idx_d = idx_q + SLOT_BITS'(1);
				end
			end
			ST_DONE: begin
				cmd.scan_done = 1'b1;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

>>> rtl/msrt_dp.sv
`timescale 1ns / 1ps

module msrt_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msrt_pkg::ctrl_cmd_t  cmd,
	input  msrt_pkg::in_item_t   in_item,
	output logic                 strobe,
	output msrt_pkg::out_item_t  result
);

	import msrt_pkg::*;

	logic [NUM_SLOTS-1:0] active_q, active_d;
	logic [CNT_BITS-1:0]  alloc_q, alloc_d;
	logic [31:0]          now_q;
	logic                 pend_valid_q, pend_valid_d;
	out_item_t            pend_q, pend_d;
	out_item_t            out_q, out_d;
	logic                 strobe_q, strobe_d;

	logic                 wr_en;
	logic [SLOT_BITS-1:0] wr_addr;
	slot_rec_t            wr_rec;
	logic [SLOT_BITS-1:0] rd_addr;
	logic [REC_BITS-1:0]  rd_raw;
	slot_rec_t            rd_rec;

	logic                 free_found;
	logic [SLOT_BITS-1:0] free_idx;
	logic [TAG_BITS-1:0]  add_tag;
	logic [32:0]          due;
	logic                 fire;
	logic                 fin;
	out_item_t            fire_item;
	out_item_t            add_item;

	msrt_ram #(
		.WIDTH(REC_BITS),
		.DEPTH(NUM_SLOTS)
	) u_slot_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_rec),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	assign rd_rec  = slot_rec_t'(rd_raw);
	assign rd_addr = cmd.tick_go ? '0 : (cmd.idx + SLOT_BITS'(1));
	assign add_tag = TAG_BITS'(in_item.tag);

	// Lowest free slot.
	always_comb begin
		free_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_idx = SLOT_BITS'(i);
			end
		end
	end
	assign free_found = ~&active_q;

	// Due test and record update for the slot under scan.
	assign due  = {1'b0, rd_rec.last_time} + {2'b00, rd_rec.period};
	assign fire = cmd.scan_en && active_q[cmd.idx] && (due < {1'b0, now_q});
	assign fin  = !rd_rec.forever_flag && (rd_rec.remaining <= 15'd1);

	always_comb begin
		active_d = active_q;
		alloc_d  = alloc_q;
		wr_en    = 1'b0;
		wr_addr  = cmd.idx;
		wr_rec   = rd_rec;

		if (cmd.add_go && free_found) begin
			wr_en               = 1'b1;
			wr_addr             = free_idx;
			wr_rec.last_time    = in_item.now_ms;
			wr_rec.period       = in_item.interval;
			wr_rec.remaining    = in_item.repeat_count;
			wr_rec.forever_flag = in_item.forever_req;
			wr_rec.tag          = add_tag;
			active_d[free_idx]  = 1'b1;
			alloc_d             = alloc_q + CNT_BITS'(1);
		end

		if (fire) begin
			wr_en            = 1'b1;
			wr_rec.last_time = now_q;
			if (fin) begin
				wr_rec.remaining   = '0;
				active_d[cmd.idx]  = 1'b0;
				if (alloc_q != '0) begin
					alloc_d = alloc_q - CNT_BITS'(1);
				end
			end else if (!rd_rec.forever_flag) begin
				wr_rec.remaining = rd_rec.remaining - 15'd1;
			end
		end
	end

	always_comb begin
		fire_item              = '0;
		fire_item.kind         = KIND_FIRE;
		fire_item.slot         = 3'(cmd.idx);
		fire_item.fired_tag    = 16'(rd_rec.tag);
		fire_item.finished     = fin;
		fire_item.active_count = 4'(alloc_d);

		add_item               = '0;
		add_item.fired_tag     = 16'(add_tag);
		add_item.last          = 1'b1;
		add_item.active_count  = 4'(alloc_d);
		if (free_found) begin
			add_item.kind = KIND_ADD_OK;
			add_item.slot = 3'(free_idx);
		end else begin
			add_item.kind = KIND_ADD_FULL;
		end
	end

	// A fire beat waits in the pending register until the next fire or the end
	// of the scan shows whether it is the last beat of the tick.
	always_comb begin
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		out_d        = out_q;
		strobe_d     = 1'b0;
		if (cmd.add_go) begin
			strobe_d = 1'b1;
			out_d    = add_item;
		end
		if (cmd.tick_go) begin
			pend_valid_d = 1'b0;
		end
		if (fire) begin
			pend_valid_d = 1'b1;
			pend_d       = fire_item;
			if (pend_valid_q) begin
				strobe_d   = 1'b1;
				out_d      = pend_q;
				out_d.last = 1'b0;
			end
		end
		if (cmd.scan_done) begin
			pend_valid_d = 1'b0;
			strobe_d     = 1'b1;
			if (pend_valid_q) begin
				out_d      = pend_q;
				out_d.last = 1'b1;
			end else begin
				out_d              = '0;
				out_d.kind         = KIND_IDLE_TICK;
				out_d.last         = 1'b1;
				out_d.active_count = 4'(alloc_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= '0;
			alloc_q      <= '0;
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			active_q     <= active_d;
			alloc_q      <= alloc_d;
			pend_valid_q <= pend_valid_d;
			strobe_q     <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_go) begin
			now_q <= in_item.now_ms;
		end
		pend_q <= pend_d;
		out_q  <= out_d;
	end

	assign strobe = strobe_q;
	assign result = out_q;

endmodule

>>> rtl/multi_slot_repeat_timer_core.sv
`timescale 1ns / 1ps

// Timer table with NUM_SLOTS slots. Raise start with an item while busy is low;
// the item is taken at that clock edge. An add item (opcode add) places the
// timer in the lowest free slot, or is rejected when the table is full, and
// gives exactly one result beat on the cycle after the item is taken; busy stays
// low, so adds may be issued in every cycle. A tick item compares every active
// slot's last time plus interval against now_ms and gives one fire beat per slot
// that is due, in slot order, or a single beat of kind "nothing fired" when no
// slot is due. A tick is taken and then holds busy high while the controller
// steps through its SCAN and DONE states, and no new item is taken until busy
// falls, because the slot records sit in a RAM with one read port that is
// walked one slot per cycle. The final beat of a tick is shown in the cycle
// right after busy falls. Results are shown for exactly one cycle with strobe
// high and cannot be stalled: the receiver must take every
// beat as it comes. The last flag marks the final beat of each item; a fire beat
// is held back until the next due slot is scanned or the scan ends, so that this
// flag can be set correctly.

module multi_slot_repeat_timer_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  msrt_pkg::in_item_t   in_item,
	output logic                 strobe,
	output msrt_pkg::out_item_t  result
);

	import msrt_pkg::*;

	ctrl_cmd_t cmd;

	// Sequencer: decodes accepted items and steps the slot scan.
	msrt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.opcode(in_item.opcode),
		.busy  (busy),
		.cmd   (cmd)
	);

	// Slot RAM, active bits, allocation count and the result registers.
	msrt_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.in_item(in_item),
		.strobe (strobe),
		.result (result)
	);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import msrt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 2 * (NUM_SLOTS + 2);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t in_item = '0;
	logic strobe;
	out_item_t result;

	multi_slot_repeat_timer_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.in_item (in_item),
		.strobe  (strobe),
		.result  (result)
	);

	// Free-running clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the timer table that the expected beats are computed from.
	logic              slot_live [NUM_SLOTS];
	logic [31:0]       slot_stamp [NUM_SLOTS];
	logic [30:0]       slot_period [NUM_SLOTS];
	logic [14:0]       slot_left [NUM_SLOTS];
	logic              slot_endless [NUM_SLOTS];
	logic [TAG_BITS-1:0] slot_tag [NUM_SLOTS];
	int unsigned       slots_in_use = 0;

	// Beats that the block still owes us, oldest first.
	out_item_t expected_beats [$];

	int unsigned error_count = 0;
	int unsigned items_sent = 0;
	int unsigned beats_checked = 0;
	int unsigned fire_beats = 0;
	int unsigned freed_beats = 0;
	int unsigned full_beats = 0;
	int unsigned quiet_ticks = 0;
	int unsigned cycle_count = 0;

	// When this is low the sender never leaves a gap between items.
	bit gaps_enabled = 1'b1;

	// Updates the shadow table with one accepted item and queues every beat
	// that the item must produce, in the order the block sends them.
	task automatic timer_table_apply(input in_item_t item);
		out_item_t beat;
		out_item_t tick_beats [$];
		logic [32:0] due_at;
		int free_idx;
		begin
			free_idx = -1;
			beat = '0;
			if (item.opcode == OP_ADD) begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (!slot_live[i] && free_idx < 0) begin
						free_idx = i;
					end
				end
				beat.fired_tag = item.tag;
				beat.last = 1'b1;
				if (free_idx >= 0) begin
					slot_live[free_idx] = 1'b1;
					slot_stamp[free_idx] = item.now_ms;
					slot_period[free_idx] = item.interval;
					slot_left[free_idx] = item.repeat_count;
					slot_endless[free_idx] = item.forever_req;
					slot_tag[free_idx] = item.tag;
					slots_in_use++;
					beat.kind = KIND_ADD_OK;
					beat.slot = 3'(free_idx);
				end else begin
					// A full table leaves the state alone and reports slot zero.
					beat.kind = KIND_ADD_FULL;
					beat.slot = '0;
				end
				beat.active_count = 4'(slots_in_use);
				expected_beats.push_back(beat);
			end else begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (slot_live[i]) begin
						// The sum is 33 bits wide, so a stamp near the top of the
						// 32-bit range simply never becomes due.
						due_at = {1'b0, slot_stamp[i]} + {2'b00, slot_period[i]};
						if (due_at < {1'b0, item.now_ms}) begin
							beat = '0;
							slot_stamp[i] = item.now_ms;
							if (!slot_endless[i]) begin
								// A count of zero is treated like a count of one.
								if (slot_left[i] <= 15'd1) begin
									slot_left[i] = '0;
									slot_live[i] = 1'b0;
									if (slots_in_use > 0) begin
										slots_in_use--;
									end
									beat.finished = 1'b1;
								end else begin
									slot_left[i] = slot_left[i] - 15'd1;
								end
							end
							beat.kind = KIND_FIRE;
							beat.slot = 3'(i);
							beat.fired_tag = slot_tag[i];
							beat.active_count = 4'(slots_in_use);
							tick_beats.push_back(beat);
						end
					end
				end
				if (tick_beats.size() == 0) begin
					beat = '0;
					beat.kind = KIND_IDLE_TICK;
					beat.active_count = 4'(slots_in_use);
					tick_beats.push_back(beat);
				end
				tick_beats[tick_beats.size() - 1].last = 1'b1;
				foreach (tick_beats[k]) begin
					expected_beats.push_back(tick_beats[k]);
				end
			end
		end
	endtask

	// Presents one item and returns at the clock edge where the block takes it.
	// Start is left high so that back-to-back items need no extra cycle.
	task automatic issue_item(input in_item_t item);
		begin
			if (gaps_enabled && $urandom_range(99) < 9) begin
				start <= 1'b0;
				repeat ($urandom_range(4, 1)) @(posedge clk);
			end
			start <= 1'b1;
			in_item <= item;
			@(posedge clk);
			while (busy) begin
				@(posedge clk);
			end
			timer_table_apply(item);
			items_sent++;
		end
	endtask

	function automatic in_item_t add_item(input logic [31:0] now, input logic [30:0] period,
			input logic [14:0] count, input logic endless, input logic [15:0] tag);
		in_item_t item;
		begin
			item.opcode = OP_ADD;
			item.now_ms = now;
			item.interval = period;
			item.repeat_count = count;
			item.forever_req = endless;
			item.tag = tag;
			return item;
		end
	endfunction

	// The add-only fields of a tick carry random junk; the block must ignore them.
	function automatic in_item_t tick_item(input logic [31:0] now);
		in_item_t item;
		begin
			item.opcode = OP_TICK;
			item.now_ms = now;
			item.interval = 31'($urandom);
			item.repeat_count = 15'($urandom);
			item.forever_req = 1'($urandom);
			item.tag = 16'($urandom);
			return item;
		end
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		begin
			if (got_val !== exp_val) begin
				$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name,
					exp_val, got_val);
				error_count++;
			end
		end
	endtask

	// Every strobed beat is taken at the edge that ends its cycle and compared
	// against the oldest outstanding expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && strobe) begin
			if (expected_beats.size() == 0) begin
				$display("%0t ns: unexpected beat kind %0d slot %0d tag %0h", $time,
					result.kind, result.slot, result.fired_tag);
				error_count++;
			end else begin
				want = expected_beats.pop_front();
				check_field("kind", 32'(want.kind), 32'(result.kind));
				check_field("slot", 32'(want.slot), 32'(result.slot));
				check_field("fired_tag", 32'(want.fired_tag), 32'(result.fired_tag));
				check_field("finished", 32'(want.finished), 32'(result.finished));
				check_field("last", 32'(want.last), 32'(result.last));
				check_field("active_count", 32'(want.active_count),
					32'(result.active_count));
				beats_checked++;
				case (want.kind)
					KIND_FIRE: begin
						fire_beats++;
						if (want.finished) begin
							freed_beats++;
						end
					end
					KIND_ADD_FULL: begin
						full_beats++;
					end
					KIND_IDLE_TICK: begin
						quiet_ticks++;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Watchdog: a hung handshake or a missing beat ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d beats still owed", cycle_count,
				expected_beats.size());
			$display("FAIL multi_slot_repeat_timer_core");
			$finish;
		end
	end

	// A tick on an empty table, then a zero-count timer next to one with the
	// widest interval. The zero-count timer is not due when now equals its
	// stamp, fires once a millisecond later, and is freed at once.
	task automatic test_quiet_tick_and_zero_count();
		begin
			issue_item(tick_item(32'd0));
			issue_item(add_item(32'd0, 31'h7FFF_FFFF, 15'd1, 1'b0, 16'hFFFF));
			issue_item(add_item(32'd0, 31'd0, 15'd0, 1'b0, 16'h0000));
			issue_item(tick_item(32'd0));
			issue_item(tick_item(32'd1));
		end
	endtask

	// Fill the remaining seven slots, try one more add, then let the seven new
	// timers fire once so that each one still has a firing left.
	task automatic test_fill_and_reject();
		begin
			for (int i = 0; i < NUM_SLOTS - 1; i++) begin
				issue_item(add_item(32'd10, 31'd5, 15'd2, 1'b0, 16'h1000 + 16'(i)));
			end
			issue_item(add_item(32'd10, 31'd5, 15'd2, 1'b0, 16'hA5A5));
			issue_item(tick_item(32'd16));
		end
	endtask

	// A tick at the largest time: all eight slots fire in one scan, including
	// the one with the widest interval, and the table empties.
	task automatic test_full_scan_at_max_time();
		begin
			issue_item(tick_item(32'hFFFF_FFFF));
		end
	endtask

	// A timer stamped near the top of the time range whose due time lies past
	// 2^32 never fires. It keeps its slot for the rest of the run.
	task automatic test_time_wrap();
		begin
			issue_item(add_item(32'hFFFF_FFF0, 31'h20, 15'd1, 1'b0, 16'h5A5A));
			issue_item(tick_item(32'hFFFF_FFFF));
		end
	endtask

	// A forever timer ignores its count and keeps firing on every due tick.
	task automatic test_forever_timer();
		begin
			issue_item(add_item(32'd100, 31'd30, 15'h7FFF, 1'b1, 16'hC3C3));
			issue_item(tick_item(32'd131));
			issue_item(tick_item(32'd162));
		end
	endtask

	// Realistic traffic on a moving clock: adds with short intervals and small
	// counts, ticks that advance time, and some ticks that jump back in time.
	task automatic test_random_traffic(input int unsigned item_total);
		logic [31:0] clock_ms;
		int unsigned endless_live;
		int unsigned pick;
		in_item_t item;
		begin
			clock_ms = 32'd200;
			for (int n = 0; n < item_total; n++) begin
				// A long middle stretch runs with no gaps at all.
				gaps_enabled = (n < item_total / 3) || (n >= (2 * item_total) / 3);
				pick = $urandom_range(99);
				if (pick < 42) begin
					endless_live = 0;
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (slot_live[i] && slot_endless[i]) begin
							endless_live++;
						end
					end
					if (endless_live < 3 && $urandom_range(9) == 0) begin
						item = add_item(clock_ms, 31'($urandom_range(40)), 15'($urandom), 1'b1,
							16'($urandom));
					end else begin
						item = add_item(clock_ms, 31'($urandom_range(40)),
							15'($urandom_range(4)), 1'b0, 16'($urandom));
					end
				end else if (pick < 90) begin
					clock_ms = clock_ms + 32'($urandom_range(25));
					item = tick_item(clock_ms);
				end else begin
					item = tick_item(32'($urandom_range(clock_ms)));
				end
				issue_item(item);
			end
			gaps_enabled = 1'b1;
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_stamp[i] = '0;
			slot_period[i] = '0;
			slot_left[i] = '0;
			slot_endless[i] = 1'b0;
			slot_tag[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_quiet_tick_and_zero_count();
		test_fill_and_reject();
		test_full_scan_at_max_time();
		test_time_wrap();
		test_forever_timer();
		test_random_traffic(310);

		start <= 1'b0;
		while (expected_beats.size() != 0) begin
			@(posedge clk);
		end
		// Give any stray beat time to show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items and checked %0d beats: %0d fires (%0d freed a slot),",
			items_sent, beats_checked, fire_beats, freed_beats);
		$display("%0d adds refused on a full table, %0d ticks with nothing due.",
			full_beats, quiet_ticks);
		if (error_count == 0) begin
			$display("PASS multi_slot_repeat_timer_core");
		end else begin
			$display("FAIL multi_slot_repeat_timer_core");
		end
		$finish;
	end

endmodule

>>> multi_slot_repeat_timer_core.f
rtl/msrt_pkg.sv
rtl/msrt_ram.sv
rtl/msrt_ctrl.sv
rtl/msrt_dp.sv
rtl/multi_slot_repeat_timer_core.sv
tb/tb_top.sv
